### rtl/core/lte_pkg.sv
// Package for the lease table engine: table geometry, opcodes, states,
// entry record and sequencer state type. No dependencies.
package lte_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_FIND_IP  = 3'd1,
        OP_FIND_MAC = 3'd2,
        OP_RELEASE  = 3'd3,
        OP_RENEW    = 3'd4,
        OP_EXPIRE   = 3'd5,
        OP_CLEANUP  = 3'd6,
        OP_NONE     = 3'd7
    } t_opcode;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;
    localparam logic [1:0] ST_EXPIRED  = 2'd2;
    localparam logic [1:0] ST_RELEASED = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    // one table entry, packed for a single RAM word
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [1:0]  state;
        logic [31:0] start_t;
        logic [31:0] end_t;
        logic [31:0] state_t;
        logic [31:0] client_t;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_DONE,
        S_OUT
    } t_state;

endpackage

### rtl/core/lte_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/lease_table_engine_core.sv
// Lease table engine top level: request/result streams, sequencer that walks
// the entry RAM. Depends on lte_pkg and lte_ram.
//
// Usage:
//   Slave stream carries one request per transfer: opcode, ip, mac, lease
//   length and current time. Master stream returns exactly one result per
//   request: status, entry index, the reported entry's fields and a count.
//   The block handles one request at a time; s_axis_tready is low from the
//   accepted transfer until the result has been taken.
//   Add and the unused opcode go straight to the result; find, release and
//   renew walk entries 0..occupancy-1 (read, register, compare per entry)
//   and stop at the first hit; expire and cleanup walk the whole occupied
//   range. The next request can be taken in the cycle after the result
//   transfer; the longest requests are the walks over the single-read
//   entry RAM.
//   Reset clears the occupancy to zero; the RAM holds no reset value and no
//   entry at or above the occupancy is ever read.
//   When the receiver stalls, the result stays in the output register and
//   no new request is taken until it is transferred.
module lease_table_engine_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [2:0] opcode, [34:3] ip_addr, [82:35] mac_addr,
    // [114:83] lease_seconds, [146:115] now_seconds, [151:147] zero
    input  logic [151:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [1:0] status, [7:2] entry_index, [39:8] lease_ip, [87:40] lease_mac,
    // [89:88] lease_state, [121:90] lease start, [153:122] lease end,
    // [185:154] state_time, [217:186] client_time, [224:218] result_count,
    // [231:225] zero
    output logic [231:0]  m_axis_tdata
);
    import lte_pkg::*;

    t_state r_state, n_state;

    // held request
    logic [2:0]  r_op;
    logic [31:0] r_ip, r_len, r_now;
    logic [47:0] r_mac;

    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_i, n_i;     // read pointer
    logic [CNT_W-1:0] r_j, n_j;     // compaction write pointer
    logic [CNT_W-1:0] r_cnt, n_cnt; // sweep count

    logic   ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry ram_wdata, ram_rdata;
    t_entry r_ent, n_ent;           // entry read or built for the result
    logic   r_hit, n_hit;

    logic [231:0] r_out;
    logic         r_oval;

    logic [32:0] sum_end;
    logic [31:0] sat_end;
    logic        accept;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign sum_end = {1'b0, r_now} + {1'b0, r_len};
    assign sat_end = sum_end[32] ? 32'hFFFF_FFFF : sum_end[31:0];

    lte_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_i[IDX_W-1:0]),
        .o_rdata(ram_rdata)
    );

    // match of the registered read against the request
    logic key_hit, drop;
    always_comb begin
        drop = (r_ent.state == ST_EXPIRED) || (r_ent.state == ST_RELEASED);
        if (r_op == OP_FIND_MAC) begin
            key_hit = (r_ent.mac == r_mac);
        end else begin
            key_hit = (r_ent.ip == r_ip);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                priority if (r_op == OP_ADD || r_op == OP_NONE) begin
                    n_state = S_DONE;
                end else if (r_i >= r_occ) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = S_WRITE;
            S_WRITE: begin
                priority if ((r_op == OP_FIND_IP || r_op == OP_FIND_MAC ||
                              r_op == OP_RELEASE || r_op == OP_RENEW) && key_hit) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: n_state = S_OUT;
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_occ     = r_occ;
        n_i       = r_i;
        n_j       = r_j;
        n_cnt     = r_cnt;
        n_ent     = r_ent;
        n_hit     = r_hit;
        ram_we    = 1'b0;
        ram_waddr = r_i[IDX_W-1:0];
        ram_wdata = r_ent;
        unique case (r_state)
            S_IDLE: begin
                n_i   = '0;
                n_j   = '0;
                n_cnt = '0;
                n_hit = 1'b0;
            end
            S_READ: begin
                if (r_op == OP_ADD && r_occ < CNT_W'(TABLE_DEPTH)) begin
                    n_ent.ip       = r_ip;
                    n_ent.mac      = r_mac;
                    n_ent.state    = ST_ACTIVE;
                    n_ent.start_t  = r_now;
                    n_ent.end_t    = sat_end;
                    n_ent.state_t  = r_now;
                    n_ent.client_t = r_now;
                    ram_we         = 1'b1;
                    ram_waddr      = r_occ[IDX_W-1:0];
                    ram_wdata      = n_ent;
                    n_occ          = r_occ + 1'b1;
                    n_hit          = 1'b1;
                    n_i            = r_occ;
                end
                if (r_op != OP_ADD && r_op != OP_NONE && r_i >= r_occ &&
                    r_op == OP_CLEANUP) begin
                    n_occ = r_j;
                end
            end
            S_CHECK: begin
                n_ent = ram_rdata;
            end
            S_WRITE: begin
                unique case (r_op)
                    OP_FIND_IP, OP_FIND_MAC: begin
                        if (key_hit) begin
                            n_hit = 1'b1;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                    OP_RELEASE: begin
                        if (key_hit) begin
                            n_ent.state    = ST_RELEASED;
                            n_ent.end_t    = r_now;
                            n_ent.state_t  = r_now;
                            n_ent.client_t = r_now;
                            ram_we         = 1'b1;
                            ram_wdata      = n_ent;
                            n_hit          = 1'b1;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                    OP_RENEW: begin
                        if (key_hit) begin
                            if (r_ent.state != ST_ACTIVE) begin
                                n_ent.state_t = r_now;
                            end
                            n_ent.state    = ST_ACTIVE;
                            n_ent.start_t  = r_now;
                            n_ent.end_t    = sat_end;
                            n_ent.client_t = r_now;
                            ram_we         = 1'b1;
                            ram_wdata      = n_ent;
                            n_hit          = 1'b1;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                    OP_EXPIRE: begin
                        if (r_ent.state == ST_ACTIVE && r_ent.end_t < r_now) begin
                            n_ent.state   = ST_EXPIRED;
                            n_ent.state_t = r_now;
                            ram_we        = 1'b1;
                            ram_wdata     = n_ent;
                            n_cnt         = r_cnt + 1'b1;
                        end
                        n_i = r_i + 1'b1;
                    end
                    OP_CLEANUP: begin
                        if (drop) begin
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            // move survivor down; a self-copy is harmless
                            ram_we    = 1'b1;
                            ram_waddr = r_j[IDX_W-1:0];
                            n_j       = r_j + 1'b1;
                        end
                        n_i = r_i + 1'b1;
                    end
                    default: n_i = r_i + 1'b1;
                endcase
            end
            default: ;
        endcase
    end

    // result assembly
    logic [231:0] result;
    logic [1:0]   res_stat;
    logic [CNT_W-1:0] res_cnt;
    always_comb begin
        priority if (r_op == OP_EXPIRE || r_op == OP_CLEANUP) begin
            res_stat = STAT_OK;
            res_cnt  = r_cnt;
        end else if (r_op == OP_ADD && !r_hit) begin
            res_stat = STAT_FULL;
            res_cnt  = r_occ;
        end else begin
            res_stat = r_hit ? STAT_OK : STAT_NOTFOUND;
            res_cnt  = r_occ;
        end
        result = '0;
        result[1:0]     = res_stat;
        result[224:218] = 7'(res_cnt);
        if (r_hit) begin
            result[7:2]     = 6'(r_i);
            result[39:8]    = r_ent.ip;
            result[87:40]   = r_ent.mac;
            result[89:88]   = r_ent.state;
            result[121:90]  = r_ent.start_t;
            result[153:122] = r_ent.end_t;
            result[185:154] = r_ent.state_t;
            result[217:186] = r_ent.client_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (r_state == S_DONE) begin
                r_oval <= 1'b1;
            end else if (r_oval && m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_j   <= n_j;
        r_cnt <= n_cnt;
        r_ent <= n_ent;
        r_hit <= n_hit;
        if (accept) begin
            r_op  <= s_axis_tdata[2:0];
            r_ip  <= s_axis_tdata[34:3];
            r_mac <= s_axis_tdata[82:35];
            r_len <= s_axis_tdata[114:83];
            r_now <= s_axis_tdata[146:115];
        end
        if (r_state == S_DONE) begin
            r_out <= result;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_out;
endmodule

### test/lease_table_checker.sv
// Checker for the lease table engine: watches both streams, keeps its own
// copy of the lease table and compares every result. Depends on lte_pkg.
module lease_table_checker
    import lte_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  logic [151:0]  i_req_data,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  logic [231:0]  i_rsp_data,
    output int            o_errors,
    output int            o_pending
);

    typedef struct packed {
        logic [6:0]  count;
        logic [31:0] client_t;
        logic [31:0] state_t;
        logic [31:0] end_t;
        logic [31:0] start_t;
        logic [1:0]  state;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [5:0]  index;
        logic [1:0]  status;
    } t_lease_rsp;

    t_entry     lease_tbl [TABLE_DEPTH];
    int         lease_occ;
    t_lease_rsp rsp_queue [$];

    assign o_pending = rsp_queue.size();

    function automatic logic [31:0] end_sat(logic [31:0] now, logic [31:0] len);
        logic [32:0] s;
        s = {1'b0, now} + {1'b0, len};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void fill_entry(inout t_lease_rsp r, input int i);
        r.index    = i[5:0];
        r.ip       = lease_tbl[i].ip;
        r.mac      = lease_tbl[i].mac;
        r.state    = lease_tbl[i].state;
        r.start_t  = lease_tbl[i].start_t;
        r.end_t    = lease_tbl[i].end_t;
        r.state_t  = lease_tbl[i].state_t;
        r.client_t = lease_tbl[i].client_t;
    endfunction

    // apply one request to the table copy and predict its result
    function automatic t_lease_rsp apply_request(logic [151:0] d);
        t_opcode     op;
        logic [31:0] ip, len, now;
        logic [47:0] mac;
        t_lease_rsp  r;
        int          hit, cnt, j;
        bit          sweep;
        op  = t_opcode'(d[2:0]);
        ip  = d[34:3];
        mac = d[82:35];
        len = d[114:83];
        now = d[146:115];
        r = '0;
        r.status = STAT_NOTFOUND;
        hit = -1;
        cnt = 0;
        sweep = 0;
        if (op inside {OP_FIND_IP, OP_RELEASE, OP_RENEW}) begin
            for (int i = 0; i < lease_occ; i++)
                if (hit < 0 && lease_tbl[i].ip == ip) hit = i;
        end
        case (op)
            OP_ADD: begin
                if (lease_occ >= TABLE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    lease_tbl[lease_occ] = '{ip, mac, ST_ACTIVE, now,
                                             end_sat(now, len), now, now};
                    lease_occ++;
                    r.status = STAT_OK;
                    fill_entry(r, lease_occ - 1);
                end
            end
            OP_FIND_IP: begin
                if (hit >= 0) begin
                    r.status = STAT_OK;
                    fill_entry(r, hit);
                end
            end
            OP_FIND_MAC: begin
                for (int i = 0; i < lease_occ; i++)
                    if (hit < 0 && lease_tbl[i].mac == mac) hit = i;
                if (hit >= 0) begin
                    r.status = STAT_OK;
                    fill_entry(r, hit);
                end
            end
            OP_RELEASE: begin
                if (hit >= 0) begin
                    lease_tbl[hit].state    = ST_RELEASED;
                    lease_tbl[hit].end_t    = now;
                    lease_tbl[hit].state_t  = now;
                    lease_tbl[hit].client_t = now;
                    r.status = STAT_OK;
                    fill_entry(r, hit);
                end
            end
            OP_RENEW: begin
                if (hit >= 0) begin
                    if (lease_tbl[hit].state != ST_ACTIVE)
                        lease_tbl[hit].state_t = now;
                    lease_tbl[hit].start_t  = now;
                    lease_tbl[hit].end_t    = end_sat(now, len);
                    lease_tbl[hit].state    = ST_ACTIVE;
                    lease_tbl[hit].client_t = now;
                    r.status = STAT_OK;
                    fill_entry(r, hit);
                end
            end
            OP_EXPIRE: begin
                for (int i = 0; i < lease_occ; i++)
                    if (lease_tbl[i].state == ST_ACTIVE && lease_tbl[i].end_t < now) begin
                        lease_tbl[i].state   = ST_EXPIRED;
                        lease_tbl[i].state_t = now;
                        cnt++;
                    end
                r.status = STAT_OK;
                sweep = 1;
            end
            OP_CLEANUP: begin
                j = 0;
                for (int i = 0; i < lease_occ; i++) begin
                    if (lease_tbl[i].state inside {ST_EXPIRED, ST_RELEASED}) cnt++;
                    else begin
                        lease_tbl[j] = lease_tbl[i];
                        j++;
                    end
                end
                lease_occ = j;
                r.status = STAT_OK;
                sweep = 1;
            end
            default: ;
        endcase
        r.count = sweep ? cnt[6:0] : lease_occ[6:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_lease_rsp got, want;
        if (!i_rst_n) begin
            lease_occ = 0;
            o_errors  = 0;
            rsp_queue = {};
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = t_lease_rsp'(i_rsp_data[224:0]);
                if (rsp_queue.size() == 0) begin
                    report_mismatch("unexpected result", got.status, 0);
                end else begin
                    want = rsp_queue.pop_front();
                    if (got.status   != want.status)   report_mismatch("status", got.status, want.status);
                    if (got.index    != want.index)    report_mismatch("entry_index", got.index, want.index);
                    if (got.ip       != want.ip)       report_mismatch("lease_ip", got.ip, want.ip);
                    if (got.mac      != want.mac)      report_mismatch("lease_mac", got.mac, want.mac);
                    if (got.state    != want.state)    report_mismatch("lease_state", got.state, want.state);
                    if (got.start_t  != want.start_t)  report_mismatch("lease_start", got.start_t, want.start_t);
                    if (got.end_t    != want.end_t)    report_mismatch("lease_end", got.end_t, want.end_t);
                    if (got.state_t  != want.state_t)  report_mismatch("state_time", got.state_t, want.state_t);
                    if (got.client_t != want.client_t) report_mismatch("client_time", got.client_t, want.client_t);
                    if (got.count    != want.count)    report_mismatch("result_count", got.count, want.count);
                end
            end
            if (i_req_valid && i_req_ready)
                rsp_queue.push_back(apply_request(i_req_data));
        end
    end

endmodule

### test/tb_lease_table_engine_core.sv
// Testbench top for the lease table engine: clock, reset, request stimulus
// and verdict. Depends on lte_pkg, lease_table_engine_core, lease_table_checker.
module tb_lease_table_engine_core;
    import lte_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    logic [151:0]  req_data = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    logic [231:0]  rsp_data;
    int            n_errors, n_pending;
    int            cycle_cnt = 0;
    int            send_idle_pct = 19;
    int            recv_idle_pct = 71;

    // small pools so that lookups hit and the table fills up
    logic [31:0]   ip_pool  [8];
    logic [47:0]   mac_pool [8];
    logic [31:0]   clock_now = 32'd1000;

    always #2 i_clk = ~i_clk;

    lease_table_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (req_valid),
        .s_axis_tready (req_ready),
        .s_axis_tdata  (req_data),
        .m_axis_tvalid (rsp_valid),
        .m_axis_tready (rsp_ready),
        .m_axis_tdata  (rsp_data)
    );

    lease_table_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_req_data  (req_data),
        .i_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .i_rsp_data  (rsp_data),
        .o_errors    (n_errors),
        .o_pending   (n_pending)
    );

    // timeout guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: stall at random with the current idle percentage
    always @(posedge i_clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    // hold one request until it is taken, with random gaps before it;
    // valid stays high on return so the next call or an idle cycle drops it
    task automatic send_req(input t_opcode op, input logic [31:0] ip,
                            input logic [47:0] mac, input logic [31:0] len,
                            input logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= {5'd0, now, len, mac, ip, op};
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
    endtask

    // mostly pooled keys and a slowly advancing clock; some fully random noise
    task automatic send_random;
        t_opcode     op;
        logic [31:0] ip, len, now;
        logic [47:0] mac;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30)      op = OP_ADD;
        else if (pick < 95) op = t_opcode'($urandom_range(1, 6));
        else                op = t_opcode'($urandom_range(7));
        if ($urandom_range(9) == 0) begin
            ip  = $urandom;
            mac = 48'({$urandom, $urandom});
            len = $urandom;
            now = $urandom;
        end else begin
            ip  = ip_pool[$urandom_range(7)];
            mac = mac_pool[$urandom_range(7)];
            len = ($urandom_range(19) == 0) ? $urandom : $urandom_range(200);
            clock_now = clock_now + $urandom_range(30);
            now = clock_now;
        end
        send_req(op, ip, mac, len, now);
    endtask

    task automatic wait_drained;
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) begin
            ip_pool[i]  = $urandom;
            mac_pool[i] = 48'({$urandom, $urandom});
        end
        ip_pool[0]  = 32'hFFFF_FFFF;
        mac_pool[0] = 48'hFFFF_FFFF_FFFF;
        ip_pool[1]  = 32'd0;
        mac_pool[1] = 48'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: misses on an empty table, extremes, saturation
        send_req(OP_FIND_IP, 32'd5, 48'd0, 32'd0, 32'd0);
        send_req(OP_CLEANUP, 32'd0, 48'd0, 32'd0, 32'd0);
        send_req(OP_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        send_req(OP_ADD, 32'd0, 48'd0, 32'd0, 32'd0);
        send_req(OP_ADD, 32'h0A00_0001, 48'h1234_5678_9ABC, 32'd10, 32'd100);
        send_req(OP_FIND_IP, 32'h0A00_0001, 48'd0, 32'd0, 32'd100);
        send_req(OP_FIND_MAC, 32'd0, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd100);
        send_req(OP_FIND_MAC, 32'd0, 48'h5555_5555_5555, 32'd0, 32'd100);
        // renew of an active lease keeps its state-change time
        send_req(OP_RENEW, 32'h0A00_0001, 48'd0, 32'd50, 32'd105);
        send_req(OP_RELEASE, 32'd0, 48'd0, 32'd0, 32'd110);
        // renew of a released lease moves its state-change time
        send_req(OP_RENEW, 32'd0, 48'd0, 32'd5, 32'd120);
        send_req(OP_RELEASE, 32'h0BAD_0000, 48'd0, 32'd0, 32'd120);
        send_req(OP_RENEW, 32'h0BAD_0000, 48'd0, 32'd0, 32'd120);
        send_req(OP_EXPIRE, 32'd0, 48'd0, 32'd0, 32'd130);
        send_req(OP_NONE, 32'd0, 48'd0, 32'd0, 32'd130);
        send_req(OP_RELEASE, 32'h0A00_0001, 48'd0, 32'd0, 32'd140);
        send_req(OP_CLEANUP, 32'd0, 48'd0, 32'd0, 32'd150);
        // fill the table to the full condition
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
            send_req(OP_ADD, $urandom, 48'({$urandom, $urandom}), 32'd20, 32'd200);
        send_req(OP_EXPIRE, 32'd0, 48'd0, 32'd0, 32'hFFFF_FFFF);
        send_req(OP_CLEANUP, 32'd0, 48'd0, 32'd0, 32'hFFFF_FFFF);

        // pause the sender until every result is back
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 71;
                recv_idle_pct = 19;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 500; n++) send_random();
        end

        wait_drained();
        repeat (3 * TABLE_DEPTH + 20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### lease_table_engine_core.f
rtl/core/lte_pkg.sv
rtl/core/lte_ram.sv
rtl/core/lease_table_engine_core.sv
test/lease_table_checker.sv
test/tb_lease_table_engine_core.sv
